// ===== src/kpsb_pkg.sv =====
// Package for the keypad scanner and button debounce block.
// Holds the word types, phase encoding, register indexes and the row decoder.
// No dependencies.
package kpsb_pkg;

    // Width of the per-key press counters (wrap at this width)
    localparam int COUNT_WIDTH = 32;

    localparam int NUM_KEYS = 9;
    localparam logic [3:0] ROWS_IDLE = 4'h0F;

    // Row line codes that select a key row
    localparam logic [3:0] ROW_CODE_0 = 4'h0B;
    localparam logic [3:0] ROW_CODE_1 = 4'h0D;
    localparam logic [3:0] ROW_CODE_2 = 4'h0E;
    localparam logic [1:0] ROW_NONE   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_KEY_TICKS = 1'b0;
    localparam logic CFG_BTN_TICKS = 1'b1;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_SCAN    = 2'd1,
        PH_RELEASE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [3:0] rows_all_low;
        logic [3:0] rows_col_one;
        logic [3:0] rows_col_two;
        logic [3:0] rows_col_three;
        logic       button_level;
    } t_in_word;

    typedef struct packed {
        logic        key_valid;
        logic [3:0]  key_index;
        logic [31:0] key_total;
        logic [1:0]  scan_phase_out;
        logic        button_pressed;
        logic        button_held;
        logic [7:0]  button_presses;
    } t_out_word;

    // Row number for one column sample, ROW_NONE when no key shows
    function automatic logic [1:0] decode_row(input logic [3:0] rows);
        logic [1:0] row;
        case (rows)
            ROW_CODE_0: row = 2'd0;
            ROW_CODE_1: row = 2'd1;
            ROW_CODE_2: row = 2'd2;
            default:    row = ROW_NONE;
        endcase
        return row;
    endfunction

endpackage

// ===== src/keypad_scan_and_button_debounce.sv =====
// A tick word is held in the input register; its result word is then loaded into the
// result register once it is free or draining. Throughput: one word per cycle unless
// the receiver stalls. The state update sits in one combinational pass.
// Reset (synchronous, active low): phase wait, all tick counters, key press
// counters and button state cleared; key threshold 2, button threshold 3.
// Top level of the 3x3 keypad scanner and push-button debounce.
// Depends on kpsb_pkg.
module keypad_scan_and_button_debounce
    import kpsb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // tick words in
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    // result words out
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    // configuration writes
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // configuration
    logic [7:0] r_key_thr;
    logic [7:0] r_btn_thr;

    // input register
    logic     r_in_valid;
    t_in_word r_in;

    // keypad state
    t_phase     r_phase,   n_phase;
    logic [7:0] r_ktick,   n_ktick;
    logic [1:0] r_lastcol, n_lastcol;
    logic [COUNT_WIDTH-1:0] r_keycnt [NUM_KEYS];

    // button state
    logic       r_down, n_down;
    logic [7:0] r_bcnt, n_bcnt;
    logic [7:0] r_btot, n_btot;
    logic       n_pressed;

    // key result of this pass
    logic                   w_hit;
    logic [3:0]             w_idx;
    logic [COUNT_WIDTH-1:0] w_total;
    logic [1:0]             w_rc1, w_rc2, w_rc3;
    logic [3:0]             w_sample;
    logic [7:0]             w_ktick_inc;
    logic [7:0]             w_bcnt_a;
    logic                   w_down_a;

    // result register
    logic      r_out_valid;
    t_out_word r_out;

    logic w_adv;

    assign o_cfg_ready = 1'b1;

    // handshake: the pass runs when the result register is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    assign w_rc1       = decode_row(r_in.rows_col_one);
    assign w_rc2       = decode_row(r_in.rows_col_two);
    assign w_rc3       = decode_row(r_in.rows_col_three);
    assign w_ktick_inc = r_ktick + 8'd1;

    // release sample under the last driven column
    always_comb begin
        case (r_lastcol)
            2'd1:    w_sample = r_in.rows_col_one;
            2'd2:    w_sample = r_in.rows_col_two;
            2'd3:    w_sample = r_in.rows_col_three;
            default: w_sample = r_in.rows_all_low;
        endcase
    end

    // keypad phase next state
    always_comb begin
        n_phase   = r_phase;
        n_ktick   = r_ktick;
        n_lastcol = r_lastcol;
        case (r_phase)
            PH_SCAN: begin
                n_phase = PH_RELEASE;
                if (w_rc1 != ROW_NONE) begin
                    n_lastcol = 2'd1;
                end else if (w_rc2 != ROW_NONE) begin
                    n_lastcol = 2'd2;
                end else begin
                    n_lastcol = 2'd3;
                end
            end
            PH_RELEASE: begin
                if (w_sample == ROWS_IDLE) begin
                    n_ktick = w_ktick_inc;
                    if (w_ktick_inc >= r_key_thr) begin
                        n_phase = PH_WAIT;
                        n_ktick = 8'd0;
                    end
                end
            end
            default: begin
                // wait, and the unused code is treated as wait
                n_phase   = PH_WAIT;
                n_lastcol = 2'd0;
                if (r_in.rows_all_low != ROWS_IDLE) begin
                    n_ktick = w_ktick_inc;
                    if (w_ktick_inc >= r_key_thr) begin
                        n_phase = PH_SCAN;
                        n_ktick = 8'd0;
                    end
                end
            end
        endcase
    end

    // keypad outputs: first column with a valid row code wins
    always_comb begin
        w_hit = 1'b0;
        w_idx = 4'd0;
        case (r_phase)
            PH_SCAN: begin
                if (w_rc1 != ROW_NONE) begin
                    w_hit = 1'b1;
                    w_idx = 4'(w_rc1);
                end else if (w_rc2 != ROW_NONE) begin
                    w_hit = 1'b1;
                    w_idx = 4'(w_rc2) + 4'd3;
                end else if (w_rc3 != ROW_NONE) begin
                    w_hit = 1'b1;
                    w_idx = 4'(w_rc3) + 4'd6;
                end
            end
            default: begin
                w_hit = 1'b0;
                w_idx = 4'd0;
            end
        endcase
    end

    assign w_total = r_keycnt[w_idx] + COUNT_WIDTH'(1);

    // button debounce: press check, then release check on the same level
    always_comb begin
        n_pressed = 1'b0;
        n_btot    = r_btot;
        w_down_a  = r_down;
        w_bcnt_a  = r_bcnt;
        if (!r_down) begin
            if (!r_in.button_level) begin
                w_bcnt_a = r_bcnt + 8'd1;
            end
            if (w_bcnt_a >= r_btn_thr) begin
                w_down_a  = 1'b1;
                w_bcnt_a  = 8'd0;
                n_btot    = r_btot + 8'd1;
                n_pressed = 1'b1;
            end
        end
        n_down = w_down_a;
        n_bcnt = w_bcnt_a;
        if (w_down_a) begin
            if (r_in.button_level) begin
                n_bcnt = w_bcnt_a + 8'd1;
            end
            if (n_bcnt >= r_btn_thr) begin
                n_down = 1'b0;
                n_bcnt = 8'd0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_thr <= 8'd2;
            r_btn_thr <= 8'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KEY_TICKS: r_key_thr <= i_cfg_data;
                CFG_BTN_TICKS: r_btn_thr <= i_cfg_data;
                default:       r_key_thr <= r_key_thr;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_word;
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT;
            r_ktick   <= 8'd0;
            r_lastcol <= 2'd0;
            r_down    <= 1'b0;
            r_bcnt    <= 8'd0;
            r_btot    <= 8'd0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_keycnt[k] <= '0;
            end
        end else if (w_adv) begin
            r_phase   <= n_phase;
            r_ktick   <= n_ktick;
            r_lastcol <= n_lastcol;
            r_down    <= n_down;
            r_bcnt    <= n_bcnt;
            r_btot    <= n_btot;
            if (w_hit) begin
                r_keycnt[w_idx] <= w_total;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.key_valid      <= w_hit;
            r_out.key_index      <= w_idx;
            r_out.key_total      <= w_hit ? 32'(w_total) : 32'd0;
            r_out.scan_phase_out <= n_phase;
            r_out.button_pressed <= n_pressed;
            r_out.button_held    <= n_down;
            r_out.button_presses <= n_btot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTH
    // a scan pass always moves on to release
    a_scan_to_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_phase == PH_SCAN) |=> r_phase == PH_RELEASE)
        else $error("scan phase did not move to release");

    // a recognized key only comes with the release phase and a legal index
    a_key_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.key_valid) |->
        (o_out_word.scan_phase_out == PH_RELEASE && o_out_word.key_index <= 4'd8))
        else $error("key result with wrong phase or index");

    // input side stalls only while a word is held and the result side is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stall without a blocked word");

    // an accepted press bumps the press total by one
    a_press_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_pressed) |=> r_btot == $past(r_btot) + 8'd1)
        else $error("button press not counted");
`endif

endmodule

// ===== bench/keypad_scoreboard.sv =====
// Scoreboard for the keypad scanner and button debounce bench: predicts each result word.
// Keeps its own copy of the keypad, key counter and button state plus both thresholds.
// Depends on kpsb_pkg.
package keypad_check_pkg;
    import kpsb_pkg::*;

    class keypad_scoreboard;
        logic [7:0] key_thr;
        logic [7:0] btn_thr;
        t_phase phase;
        logic [7:0] key_ticks;
        logic [1:0] last_col;
        logic [COUNT_WIDTH-1:0] key_counts [NUM_KEYS];
        logic btn_down;
        logic [7:0] btn_ticks;
        logic [7:0] btn_total;
        t_out_word expected_words [$];
        int error_count;

        // Power-up state, same as after reset
        function new();
            key_thr = 8'd2;
            btn_thr = 8'd3;
            phase = PH_WAIT;
            key_ticks = '0;
            last_col = '0;
            foreach (key_counts[k]) key_counts[k] = '0;
            btn_down = 1'b0;
            btn_ticks = '0;
            btn_total = '0;
            error_count = 0;
        endfunction

        function void set_reg(logic idx, logic [7:0] val);
            if (idx == CFG_KEY_TICKS) begin
                key_thr = val;
            end else begin
                btn_thr = val;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Advance the keypad and button state by one tick word, queue the result word
        function void note_tick(t_in_word w);
            logic [3:0] rows [4];
            t_out_word want;
            logic hit;
            int row;
            int c;
            rows[0] = w.rows_all_low;
            rows[1] = w.rows_col_one;
            rows[2] = w.rows_col_two;
            rows[3] = w.rows_col_three;
            want = '0;
            hit = 1'b0;
            row = 0;

            case (phase)
                // walk the columns, first recognized row code wins
                PH_SCAN: begin
                    for (c = 1; c <= 3 && !hit; c++) begin
                        last_col = 2'(c);
                        hit = 1'b1;
                        case (rows[c])
                            ROW_CODE_0: row = 0;
                            ROW_CODE_1: row = 1;
                            ROW_CODE_2: row = 2;
                            default:    hit = 1'b0;
                        endcase
                        if (hit) begin
                            want.key_index = 4'((c - 1) * 3 + row);
                            key_counts[want.key_index] = key_counts[want.key_index] + 1'b1;
                            want.key_total = 32'(key_counts[want.key_index]);
                            want.key_valid = 1'b1;
                        end
                    end
                    phase = PH_RELEASE;
                end
                // idle samples under the last driven column
                PH_RELEASE: begin
                    if (rows[last_col] == ROWS_IDLE) begin
                        key_ticks = key_ticks + 1'b1;
                        if (key_ticks >= key_thr) begin
                            phase = PH_WAIT;
                            key_ticks = '0;
                        end
                    end
                end
                // wait for a non-idle sample with all columns low
                default: begin
                    phase = PH_WAIT;
                    last_col = '0;
                    if (rows[0] != ROWS_IDLE) begin
                        key_ticks = key_ticks + 1'b1;
                        if (key_ticks >= key_thr) begin
                            phase = PH_SCAN;
                            key_ticks = '0;
                        end
                    end
                end
            endcase

            // button: press check, then release check on the same level
            if (!btn_down) begin
                if (!w.button_level) btn_ticks = btn_ticks + 1'b1;
                if (btn_ticks >= btn_thr) begin
                    btn_down = 1'b1;
                    btn_ticks = '0;
                    btn_total = btn_total + 1'b1;
                    want.button_pressed = 1'b1;
                end
            end
            if (btn_down) begin
                if (w.button_level) btn_ticks = btn_ticks + 1'b1;
                if (btn_ticks >= btn_thr) begin
                    btn_down = 1'b0;
                    btn_ticks = '0;
                end
            end

            want.scan_phase_out = phase;
            want.button_held = btn_down;
            want.button_presses = btn_total;
            expected_words.push_back(want);
        endfunction

        // Compare one accepted result word against the oldest prediction
        function void check_result(t_out_word got);
            t_out_word want;
            if (expected_words.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result word %h, nothing pending", got);
                return;
            end
            want = expected_words.pop_front();
            if (got.key_valid !== want.key_valid || got.key_index !== want.key_index ||
                got.key_total !== want.key_total ||
                got.scan_phase_out !== want.scan_phase_out ||
                got.button_pressed !== want.button_pressed ||
                got.button_held !== want.button_held ||
                got.button_presses !== want.button_presses) begin
                error_count++;
                if (error_count <= 10)
                    $display({"result mismatch: expected valid=%0d index=%0d total=%0d ",
                              "phase=%0d pressed=%0d held=%0d presses=%0d; got valid=%0d ",
                              "index=%0d total=%0d phase=%0d pressed=%0d held=%0d presses=%0d"},
                             want.key_valid, want.key_index, want.key_total,
                             want.scan_phase_out, want.button_pressed, want.button_held,
                             want.button_presses, got.key_valid, got.key_index,
                             got.key_total, got.scan_phase_out, got.button_pressed,
                             got.button_held, got.button_presses);
            end
        endfunction

        // Any predictions never matched by a result count as one error
        function int close_out();
            if (expected_words.size() != 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0d result words never arrived", expected_words.size());
            end
            return error_count;
        endfunction
    endclass

endpackage

// ===== bench/keypad_scan_and_button_debounce_test.sv =====
// Bench for keypad_scan_and_button_debounce: directed ticks, then random key gestures
// and button runs under several threshold settings, with random sender and receiver stalls.
// Depends on kpsb_pkg and keypad_check_pkg.
module keypad_scan_and_button_debounce_test;
    import kpsb_pkg::*;
    import keypad_check_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_word   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_word  out_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data = '0;

    keypad_scoreboard sb;

    keypad_scan_and_button_debounce dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic t_in_word tick_word(logic [3:0] all_low, logic [3:0] c1,
                                           logic [3:0] c2, logic [3:0] c3, logic level);
        t_in_word w;
        w.rows_all_low = all_low;
        w.rows_col_one = c1;
        w.rows_col_two = c2;
        w.rows_col_three = c3;
        w.button_level = level;
        return w;
    endfunction

    function automatic logic [3:0] row_code(int r);
        case (r)
            0:       return ROW_CODE_0;
            1:       return ROW_CODE_1;
            default: return ROW_CODE_2;
        endcase
    endfunction

    // Non-idle row sample that selects no key
    function automatic logic [3:0] stray_rows();
        logic [3:0] v;
        do v = 4'($urandom_range(0, 14));
        while (v == ROW_CODE_0 || v == ROW_CODE_1 || v == ROW_CODE_2);
        return v;
    endfunction

    task automatic send_tick(input t_in_word w);
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        sb.note_tick(w);
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    // Drain the block, then load both thresholds
    task automatic apply_settings(input logic [7:0] key_thr, input logic [7:0] btn_thr);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(CFG_KEY_TICKS, key_thr);
        write_reg(CFG_BTN_TICKS, btn_thr);
        cfg_valid <= 1'b0;
    endtask

    // Key press gestures (hold, then release) with random content, bounce and noise;
    // button runs that are either glitches or full-length holds
    task automatic run_random_ticks(input int count, input int key_thr, input int btn_thr);
        int press_left;
        int release_left;
        int btn_left;
        int burst_left;
        int key_col;
        int n;
        int c;
        logic [3:0] code;
        logic [3:0] cols [1:3];
        logic level;
        logic noisy;
        t_in_word w;
        press_left = 0;
        release_left = 0;
        btn_left = 0;
        burst_left = $urandom_range(1, 40);
        key_col = 4;
        code = ROWS_IDLE;
        level = 1'b1;
        noisy = 1'b0;
        for (n = 0; n < count; n++) begin
            if (btn_left == 0) begin
                level = ~level;
                btn_left = $urandom_range(0, 1) ? $urandom_range(1, 3)
                                                : btn_thr + $urandom_range(1, 4);
            end
            btn_left--;

            if (press_left == 0 && release_left == 0) begin
                c = $urandom_range(0, 9);  // 9: a press that shows no valid row code
                key_col = (c == 9) ? 4 : c / 3 + 1;
                code = (c == 9) ? stray_rows() : row_code(c % 3);
                noisy = ($urandom_range(0, 5) == 0);
                press_left = key_thr + $urandom_range(1, 4);
                release_left = key_thr + $urandom_range(1, 4);
            end
            if (press_left > 0) begin
                press_left--;
                for (c = 1; c <= 3; c++) begin
                    if (c < key_col) begin
                        cols[c] = $urandom_range(0, 1) ? ROWS_IDLE : stray_rows();
                    end else if (c == key_col) begin
                        cols[c] = code;
                    end else begin
                        cols[c] = 4'($urandom);
                    end
                end
                w = tick_word(code, cols[1], cols[2], cols[3], level);
                if (noisy || $urandom_range(0, 15) == 0) w = t_in_word'($urandom);
            end else begin
                release_left--;
                w = tick_word(ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, level);
                // contact bounce
                if ($urandom_range(0, 7) == 0) w = t_in_word'($urandom);
            end
            w.button_level = level;
            send_tick(w);

            burst_left--;
            if (burst_left == 0) begin
                pause_sender($urandom_range(1, 8));
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    // Result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
    end

    // Receiver stall pattern, with one long hold-off early on
    initial begin : result_stall
        int mode;
        int span;
        int k;
        wait (rst_n);
        repeat (10) @(posedge clk);
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        out_stall <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            for (k = 0; k < span; k++) begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= (k % 3 == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Stimulus sequence
    initial begin : stimulus
        logic [7:0] key_thr;
        logic [7:0] btn_thr;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks at reset thresholds (key 2, button 3)
        send_tick(tick_word(4'h0, 4'h0, 4'h0, 4'h0, 1'b0));
        send_tick(tick_word(ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, 1'b1));
        // no key found: the scan sees idle columns, and release then samples column three
        send_tick(tick_word(ROW_CODE_0, ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, 1'b0));
        send_tick(tick_word(ROW_CODE_0, ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, 1'b0));
        send_tick(tick_word(ROWS_IDLE, ROWS_IDLE, ROW_CODE_1, 4'h0, 1'b0));
        send_tick(tick_word(ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, 1'b1));
        send_tick(tick_word(ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, 1'b1));
        // last key: column three, row two
        send_tick(tick_word(ROW_CODE_2, 4'h0, 4'h0, 4'h0, 1'b1));
        send_tick(tick_word(ROW_CODE_2, 4'h0, 4'h0, 4'h0, 1'b1));
        send_tick(tick_word(ROWS_IDLE, 4'h7, 4'h3, ROW_CODE_2, 1'b0));
        send_tick(tick_word(ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, 1'b0));
        send_tick(tick_word(ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, 1'b0));
        // nothing found through column three; release then samples column three
        send_tick(tick_word(ROW_CODE_1, 4'h0, 4'h0, 4'h0, 1'b1));
        send_tick(tick_word(ROW_CODE_1, 4'h0, 4'h0, 4'h0, 1'b1));
        send_tick(tick_word(4'h0, 4'h0, 4'h0, 4'h0, 1'b1));
        send_tick(tick_word(4'h0, 4'h0, 4'h0, ROWS_IDLE, 1'b1));
        send_tick(tick_word(4'h0, ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, 1'b1));
        // first key: column one, row zero, with every column showing a code
        send_tick(tick_word(4'h7, ROW_CODE_0, ROW_CODE_0, ROW_CODE_0, 1'b0));
        send_tick(tick_word(4'h7, ROW_CODE_0, ROW_CODE_0, ROW_CODE_0, 1'b0));
        send_tick(tick_word(ROWS_IDLE, ROW_CODE_0, ROW_CODE_1, ROW_CODE_2, 1'b0));
        send_tick(tick_word(ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, 1'b1));
        send_tick(tick_word(ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, ROWS_IDLE, 1'b1));
        send_tick(tick_word(4'h5, 4'hA, 4'hC, 4'h1, 1'b0));
        send_tick(tick_word(4'hA, 4'h5, 4'h3, 4'hC, 1'b1));

        run_random_ticks(180, 2, 3);
        apply_settings(8'd1, 8'd1);
        run_random_ticks(120, 1, 1);
        // zero thresholds: every button tick presses and releases at once
        apply_settings(8'd0, 8'd0);
        run_random_ticks(270, 0, 0);
        apply_settings(8'd255, 8'd255);
        run_random_ticks(540, 255, 255);
        key_thr = 8'($urandom_range(3, 12));
        btn_thr = 8'($urandom_range(2, 10));
        apply_settings(key_thr, btn_thr);
        run_random_ticks(120, key_thr, btn_thr);

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.close_out() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/kpsb_pkg.sv
src/keypad_scan_and_button_debounce.sv
bench/keypad_scoreboard.sv
bench/keypad_scan_and_button_debounce_test.sv
